[sv/ntc_pkg.sv]
`timescale 1ns / 1ps
// Package for the NTC thermistor lookup: the resistance table, the pipeline item type
// and the midpoint function. Used by every module of the block.
package ntc_pkg;

    localparam int ADC_FULL_SCALE = 4096;
    localparam int TABLE_ENTRIES  = 181;
    localparam int STORED         = 181;
    localparam int LIMIT = (TABLE_ENTRIES > STORED) ? STORED :
                           ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);
    localparam int ADC_W   = 12;
    localparam int IDX_W   = 8;
    localparam int STEPS   = IDX_W;
    localparam int D_W     = $clog2(ADC_FULL_SCALE + 1);
    localparam int N_W     = 26;
    localparam int M_W     = 20;
    localparam int P_W     = M_W + D_W;
    localparam int TEMP_OFFSET = 55;
    localparam logic [13:0] R_SCALE_Q4 = 14'd16000;

    typedef logic [15:0] t_ohm;

    localparam t_ohm OHM_TABLE [STORED] = '{
        58354, 55464, 52698, 50048, 47515, 45097, 42789, 40589, 38492, 36496,
        34597, 32791, 31075, 29444, 27896, 26427, 25034, 23713, 22460, 21273,
        20148, 19083, 18075, 17120, 16216, 15361, 14551, 13785, 13061, 12376,
        11728, 11114, 10535, 9986, 9468, 8977, 8513, 8075, 7660, 7267,
        6896, 6545, 6212, 5898, 5601, 5319, 5053, 4801, 4562, 4336,
        4122, 3920, 3728, 3546, 3374, 3211, 3057, 2910, 2771, 2639,
        2515, 2396, 2284, 2177, 2076, 1978, 1889, 1802, 1720, 1642,
        1568, 1497, 1430, 1366, 1306, 1248, 1193, 1141, 1092, 1044,
        1000, 957, 916, 877, 840, 805, 771, 739, 709, 679,
        652, 625, 600, 576, 552, 530, 509, 489, 470, 452,
        434, 417, 401, 386, 371, 358, 344, 331, 318, 306,
        295, 284, 274, 264, 254, 245, 236, 228, 220, 212,
        205, 198, 191, 184, 178, 172, 166, 160, 155, 150,
        145, 140, 135, 131, 126, 122, 118, 115, 111, 107,
        104, 101, 97, 94, 91, 89, 86, 83, 81, 78,
        76, 74, 71, 69, 67, 65, 63, 61, 60, 58,
        56, 55, 53, 52, 50, 49, 47, 46, 45, 43,
        42, 41, 40, 39, 38, 37, 36, 35, 34, 33,
        32
    };

    // One item in flight: dividend, divisor, saturation flag and the index built so far.
    typedef struct packed {
        logic             vld;
        logic             sat;
        logic [N_W-1:0]   n;
        logic [D_W-1:0]   d;
        logic [IDX_W-1:0] k;
    } t_item;

    // Decision point between entry c-1 and entry c, in q4 units: 8 * (e[c] + e[c-1]).
    // The nearest index is the count of points that the resistance lies strictly below.
    function automatic logic [M_W-1:0] mid_q4(input logic [IDX_W-1:0] c);
        logic [16:0] s;
        s = 17'd0;
        if (c != '0 && int'(c) < STORED) begin
            s = {1'b0, OHM_TABLE[c]} + {1'b0, OHM_TABLE[c - 1'b1]};
        end
        return {s, 3'b000};
    endfunction

endpackage

[sv/ntc_search_step.sv]
`timescale 1ns / 1ps
// One bit of the binary search for the nearest table entry, over two register stages.
// Depends on ntc_pkg.
module ntc_search_step import ntc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [$clog2(IDX_W)-1:0] i_bit,
    input  t_item                    i_item,
    output t_item                    o_item
);

    t_item          r_a;
    logic           r_ok;
    logic [P_W-1:0] r_prod;
    t_item          r_b;

    logic [IDX_W-1:0] cand;
    logic [IDX_W-1:0] cand_a;
    logic             n_ok;
    t_item            n_b;

    // Candidate index: the bits found so far with this bit set.
    assign cand = i_item.k | (IDX_W'(1) << i_bit);
    assign n_ok = (int'(cand) <= LIMIT - 1) && !i_item.sat;
    assign cand_a = r_a.k | (IDX_W'(1) << i_bit);

    // First stage: scale the divisor by the decision point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
        end else if (i_en) begin
            r_a    <= i_item;
            r_ok   <= n_ok;
            r_prod <= mid_q4(cand) * P_W'(i_item.d);
        end
    end

    // floor(n/d) < m exactly when n < m*d; keep the bit if so.
    always_comb begin
        n_b = r_a;
        if (r_ok && P_W'(r_a.n) < r_prod) begin
            n_b.k = cand_a;
        end
    end

    // Second stage: register the item with the decided bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
        end else if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_item = r_b;

endmodule

[sv/ntc_thermistor_temperature_lookup_core.sv]
`timescale 1ns / 1ps
// Top level of the NTC thermistor lookup: input stage and the chain of search steps.
// Depends on ntc_pkg and ntc_search_step.
//
// Usage: one beat on the input channel (i_valid/o_ready, i_adc_value) carries a raw
// 12-bit sample. One beat on the output channel (o_valid/i_ready) carries the nearest
// table index and the temperature in degrees C (index - 55).
// The resistance 16000*adc/(full_scale-adc) is never divided out: each of the eight
// index bits is decided by comparing the dividend with a table midpoint times the
// divisor, one multiplier per bit, two register stages per bit.
// A beat is registered in the input stage, then in both stages of each search step.
// Throughput: one beat per cycle unless the receiver stalls; the pipeline is set by the eight search steps.
// Reset clears all valid bits; no output beat appears until an input beat is taken.
// When the receiver stalls with a result shown, the whole pipeline holds and
// o_ready drops; nothing is lost or repeated.
module ntc_thermistor_temperature_lookup_core import ntc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ADC_W-1:0]        i_adc_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [IDX_W-1:0] o_temperature_c,
    output logic [IDX_W-1:0]        o_table_index
);

    t_item r_s0;
    t_item chain [STEPS+1];
    logic  en;

    // The pipeline moves whenever the output slot is empty or being taken.
    assign en      = !chain[STEPS].vld || i_ready;
    assign o_ready = en;

    // Input stage: dividend, divisor and the at-or-above-full-scale case.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else if (en) begin
            r_s0.vld <= i_valid;
            r_s0.sat <= (int'(i_adc_value) >= ADC_FULL_SCALE);
            r_s0.n   <= N_W'(R_SCALE_Q4) * N_W'(i_adc_value);
            r_s0.d   <= D_W'(ADC_FULL_SCALE - int'(i_adc_value));
            r_s0.k   <= '0;
        end
    end

    assign chain[0] = r_s0;

    // Search steps, most significant index bit first.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        ntc_search_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_bit  ($clog2(IDX_W)'(STEPS - 1 - g)),
            .i_item (chain[g]),
            .o_item (chain[g+1])
        );
    end

    assign o_valid         = chain[STEPS].vld;
    assign o_table_index   = chain[STEPS].k;
    assign o_temperature_c = chain[STEPS].k - IDX_W'(TEMP_OFFSET);

endmodule

[sv/ntc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the NTC thermistor lookup, bound to the top level.
// Depends on ntc_pkg.
module ntc_checker import ntc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic signed [IDX_W-1:0] o_temperature_c,
    input logic [IDX_W-1:0]        o_table_index
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_table_index)))
        else $error("stalled output beat changed");

    // Temperature follows the index.
    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_c == o_table_index - IDX_W'(TEMP_OFFSET)))
        else $error("temperature does not match index");

    // Index stays within the table.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_table_index) < LIMIT))
        else $error("index beyond table");

    // Input is refused only while a result waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input refused without output stall");

endmodule

bind ntc_thermistor_temperature_lookup_core ntc_checker u_ntc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_temperature_c(o_temperature_c),
    .o_table_index  (o_table_index)
);

[tb/ntc_thermistor_temperature_lookup_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for the NTC thermistor lookup core: random and directed ADC samples,
// a nearest-entry predictor and an in-order scoreboard. Depends on ntc_pkg and the core.
module ntc_thermistor_temperature_lookup_core_tb;
    import ntc_pkg::*;

    // Expected lookup for one sample.
    typedef struct {
        logic signed [7:0] temp;
        logic [7:0]        idx;
    } t_lookup;

    // Scoreboard: predicts each accepted sample and checks results in order.
    class lookup_scoreboard;
        t_lookup pending[$];
        int      mismatches;

        function t_lookup predict(logic [11:0] adc);
            longint unsigned r;
            longint unsigned d;
            longint unsigned best_d;
            longint unsigned e;
            int              best;
            int              lim;
            t_lookup         res;
            if (adc >= ADC_FULL_SCALE) begin
                r = 65535 * 16;
            end else begin
                r = (64'd16000 * adc) / (ADC_FULL_SCALE - adc);
                if (r > 65535 * 16) r = 65535 * 16;
            end
            lim = (TABLE_ENTRIES > 181) ? 181 : TABLE_ENTRIES;
            e = OHM_TABLE[0] * 16;
            best_d = (r >= e) ? r - e : e - r;
            best = 0;
            for (int i = 1; i < lim; i++) begin
                e = OHM_TABLE[i] * 16;
                d = (r >= e) ? r - e : e - r;
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            res.idx = best[7:0];
            res.temp = 8'(best - 55);
            return res;
        endfunction

        function void note_sample(logic [11:0] adc);
            pending.push_back(predict(adc));
        endfunction

        function void check_result(logic [7:0] temp, logic [7:0] idx);
            t_lookup exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat idx=%0d", idx);
                return;
            end
            exp_r = pending.pop_front();
            if (exp_r.temp !== temp || exp_r.idx !== idx) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected temp=%0d idx=%0d, got temp=%0d idx=%0d",
                             exp_r.temp, exp_r.idx, $signed(temp), idx);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [ADC_W-1:0]  i_adc_value;
    logic              o_valid;
    logic              i_ready;
    logic signed [7:0] o_temperature_c;
    logic [7:0]        o_table_index;

    lookup_scoreboard sb;
    bit               stim_done;
    int               stall_mode;

    logic [11:0] adc_dir [20] = '{
        12'd0, 12'd1, 12'd2, 12'd4095, 12'd4094, 12'd4093, 12'd4080, 12'd2048,
        12'd2047, 12'd2731, 12'd3562, 12'd3780, 12'd3800, 12'd1000, 12'd500,
        12'd100, 12'd30, 12'd3, 12'hAAA, 12'h555
    };

    ntc_thermistor_temperature_lookup_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_adc_value(i_adc_value), .o_valid(o_valid), .i_ready(i_ready),
        .o_temperature_c(o_temperature_c), .o_table_index(o_table_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Send one sample beat; valid holds until the beat is taken.
    task automatic send_sample(logic [11:0] adc);
        i_valid <= 1'b1;
        i_adc_value <= adc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(adc);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Receiver: ready follows a pattern that changes mode every so often.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= ($urandom_range(0, 1) != 0);
                default: i_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Check each result beat at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_temperature_c, o_table_index);
    end

    initial begin
        logic [11:0] adc;
        int          burst;
        int          wait_cycles;
        sb = new();
        stall_mode = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_adc_value = '0;
        i_ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: range ends, near full scale, bit patterns and table tie points.
        foreach (adc_dir[k]) send_sample(adc_dir[k]);
        idle_gap(3);

        // Random bursts: half uniform, half clustered at the ends of the range.
        for (int n = 0; n < 700; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) begin
                case ($urandom_range(0, 3))
                    0: adc = $urandom_range(0, 63);
                    1: adc = $urandom_range(4000, 4095);
                    default: adc = $urandom_range(0, 4095);
                endcase
                send_sample(adc);
                n++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (sb.pending.size() == 0 && sb.mismatches == 0)
            $display("ntc_thermistor_temperature_lookup_core_tb: clean");
        else
            $display("ntc_thermistor_temperature_lookup_core_tb: errors");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20ms;
        $display("ntc_thermistor_temperature_lookup_core_tb: errors");
        $finish;
    end
endmodule
